// ===== src/assert_macros.svh =====
// Assertion macros shared by the checker files.
// Needs a clk and a rst signal in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lbp_pkg.sv =====
// Shared types and constants for the 3x3 LBP block and its checker.
// No dependencies.
`default_nettype none

package lbp_pkg;

  localparam int PIX_W  = 8;
  localparam int CFG_W  = 9;
  localparam int CNT_W  = 16;
  localparam int BINS   = 256;
  localparam int BIN_W  = 8;
  localparam int MIN_SIZE = 3;

  typedef enum logic {
    REQ_PIXEL = 1'b0,
    REQ_READ  = 1'b1
  } req_t;

  typedef enum logic [0:0] {
    CFG_IMAGE_WIDTH  = 1'b0,
    CFG_IMAGE_HEIGHT = 1'b1
  } cfg_idx_t;

  // neighbour weights
  localparam logic [PIX_W-1:0] WT_TL = 8'd128;
  localparam logic [PIX_W-1:0] WT_T  = 8'd64;
  localparam logic [PIX_W-1:0] WT_TR = 8'd32;
  localparam logic [PIX_W-1:0] WT_R  = 8'd16;
  localparam logic [PIX_W-1:0] WT_BR = 8'd8;
  localparam logic [PIX_W-1:0] WT_B  = 8'd4;
  localparam logic [PIX_W-1:0] WT_BL = 8'd2;
  localparam logic [PIX_W-1:0] WT_L  = 8'd1;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

`default_nettype wire

// ===== src/lbp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Read returns the old contents on a same-address write. No dependencies.
`default_nettype none

module lbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/lbp_3x3_with_histogram.sv =====
// 3x3 local binary pattern with a 256-bin code histogram.
// Uses lbp_pkg and lbp_ram (line store and histogram memories).
//
// Usage:
//   Input channel (in_valid/in_ready): req_type 0 carries a raster pixel in
//   pixel_value, req_type 1 asks for the count of histogram bin bin_index.
//   Output channel (out_valid/out_ready): one item per input item, in order.
//   A pixel gives lbp_code of the centre one row and one column behind it,
//   code_valid for interior centres and frame_done on the frame's last pixel;
//   a read gives bin_count. Config port: cfg_we writes cfg_data into the
//   register at cfg_index (0 image_width, 1 image_height) and restarts the
//   frame at row 0, column 0.
//   Items pass stage 1, stage 2 and the output register, one item per cycle
//   while out_ready is high. The line store is read-modify-written once per
//   pixel and the histogram once per code, each memory port once a cycle.
//   The histogram is cleared when the first pixel of a frame passes, via
//   per-bin valid flops; no clearing pass is needed.
//   Reset (rst, synchronous) empties the pipeline, sets both sizes to 256
//   and zeroes the histogram. When the receiver stalls, the whole pipeline
//   holds and in_ready drops until the output register is taken.
`default_nettype none

module lbp_3x3_with_histogram
  import lbp_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic             req_type,
  input  wire logic [PIX_W-1:0] pixel_value,
  input  wire logic [BIN_W-1:0] bin_index,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [PIX_W-1:0] lbp_code,
  output logic                  code_valid,
  output logic                  frame_done,
  output logic      [CNT_W-1:0] bin_count
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int SH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  // configuration and position
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;
  logic [CW-1:0]    col_count;
  logic [RW-1:0]    row_count;
  logic [SW-1:0]    w_ext, w_clamp;
  logic [SH-1:0]    h_ext, h_clamp;
  logic [CW-1:0]    wm1;
  logic [RW-1:0]    hm1;

  logic adv;
  logic accept;

  // stage 1: line store data returns
  logic             s1_valid;
  logic             s1_read;
  logic [PIX_W-1:0] s1_pix;
  logic [BIN_W-1:0] s1_bin;
  logic [CW-1:0]    s1_col;
  logic             s1_interior;
  logic             s1_done;
  logic             s1_first;

  // window: columns 1 and 2, rows top/mid/bottom
  logic [PIX_W-1:0] win1 [3];
  logic [PIX_W-1:0] win2 [3];

  logic [2*PIX_W-1:0] line_q;
  logic [PIX_W-1:0]   top, mid;
  logic               line_we;
  logic [PIX_W-1:0]   code;
  logic [BIN_W-1:0]   hist_raddr;

  // stage 2: histogram data returns
  logic             s2_valid;
  logic             s2_read;
  logic [PIX_W-1:0] s2_code;
  logic             s2_interior;
  logic             s2_done;
  logic             s2_first;
  logic [BIN_W-1:0] s2_addr;

  logic [CNT_W-1:0] hist_q;
  logic [BINS-1:0]  hist_vld;
  logic             hist_we;
  logic [CNT_W-1:0] cur_count;
  logic [CNT_W-1:0] inc_count;

  // last histogram write, for the read issued in the same cycle
  logic             lw_valid;
  logic [BIN_W-1:0] lw_addr;
  logic [CNT_W-1:0] lw_data;

  always_comb begin
    w_ext = SW'(image_width);
    if (w_ext < SW'(MIN_SIZE)) begin
      w_clamp = SW'(MIN_SIZE);
    end else if (w_ext > SW'(MAX_WIDTH)) begin
      w_clamp = SW'(MAX_WIDTH);
    end else begin
      w_clamp = w_ext;
    end
    h_ext = SH'(image_height);
    if (h_ext < SH'(MIN_SIZE)) begin
      h_clamp = SH'(MIN_SIZE);
    end else if (h_ext > SH'(MAX_HEIGHT)) begin
      h_clamp = SH'(MAX_HEIGHT);
    end else begin
      h_clamp = h_ext;
    end
    wm1 = CW'(w_clamp - SW'(1));
    hm1 = RW'(h_clamp - SH'(1));
  end

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign accept   = in_valid && in_ready;

  // registers and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= CFG_W'(256);
      image_height <= CFG_W'(256);
      col_count    <= '0;
      row_count    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_WIDTH:  image_width  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height <= cfg_data;
        default:          image_width  <= image_width;
      endcase
      col_count <= '0;
      row_count <= '0;
    end else if (accept && req_type == REQ_PIXEL) begin
      if (col_count == wm1) begin
        col_count <= '0;
        row_count <= (row_count == hm1) ? '0 : row_count + RW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  // stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_read     <= (req_type == REQ_READ);
      s1_pix      <= pixel_value;
      s1_bin      <= bin_index;
      s1_col      <= col_count;
      s1_interior <= (row_count >= RW'(2)) && (col_count >= CW'(2));
      s1_done     <= (row_count == hm1) && (col_count == wm1);
      s1_first    <= (row_count == '0) && (col_count == '0);
    end
  end

  // line store: upper half holds row r-2, lower half row r-1
  lbp_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk  (clk),
    .we   (line_we),
    .waddr(s1_col),
    .wdata({mid, s1_pix}),
    .re   (accept && req_type == REQ_PIXEL),
    .raddr(col_count),
    .rdata(line_q)
  );

  assign top     = line_q[2*PIX_W-1:PIX_W];
  assign mid     = line_q[PIX_W-1:0];
  assign line_we = adv && s1_valid && !s1_read;

  // pattern of the window after this pixel shifts in; centre is old win2 mid
  always_comb begin
    code = '0;
    if (win1[0] >= win2[1]) code = code | WT_TL;
    if (win2[0] >= win2[1]) code = code | WT_T;
    if (top     >= win2[1]) code = code | WT_TR;
    if (mid     >= win2[1]) code = code | WT_R;
    if (s1_pix  >= win2[1]) code = code | WT_BR;
    if (win2[2] >= win2[1]) code = code | WT_B;
    if (win1[2] >= win2[1]) code = code | WT_BL;
    if (win1[1] >= win2[1]) code = code | WT_L;
    hist_raddr = s1_read ? s1_bin : code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        win1[k] <= '0;
        win2[k] <= '0;
      end
    end else if (line_we) begin
      for (int k = 0; k < 3; k++) begin
        win1[k] <= win2[k];
      end
      win2[0] <= top;
      win2[1] <= mid;
      win2[2] <= s1_pix;
    end
  end

  // stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_read     <= s1_read;
      s2_code     <= s1_interior ? code : '0;
      s2_interior <= s1_interior;
      s2_done     <= s1_done;
      s2_first    <= s1_first;
      s2_addr     <= hist_raddr;
    end
  end

  lbp_ram #(
    .WIDTH(CNT_W),
    .DEPTH(BINS)
  ) u_hist_ram (
    .clk  (clk),
    .we   (hist_we),
    .waddr(s2_addr),
    .wdata(inc_count),
    .re   (adv),
    .raddr(hist_raddr),
    .rdata(hist_q)
  );

  always_comb begin
    if (lw_valid && lw_addr == s2_addr) begin
      cur_count = lw_data;
    end else if (hist_vld[s2_addr]) begin
      cur_count = hist_q;
    end else begin
      cur_count = '0;
    end
    inc_count = (cur_count == CNT_MAX) ? cur_count : cur_count + CNT_W'(1);
  end

  assign hist_we = adv && s2_valid && !s2_read && s2_interior;

  always_ff @(posedge clk) begin
    if (rst) begin
      hist_vld <= '0;
      lw_valid <= 1'b0;
    end else if (adv) begin
      lw_valid <= hist_we;
      if (s2_valid && !s2_read && s2_first) begin
        hist_vld <= '0;
      end else if (hist_we) begin
        hist_vld[s2_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lw_addr <= s2_addr;
      lw_data <= inc_count;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lbp_code   <= s2_read ? '0 : s2_code;
      code_valid <= !s2_read && s2_interior;
      frame_done <= !s2_read && s2_done;
      bin_count  <= s2_read ? cur_count : '0;
    end
  end

endmodule

`default_nettype wire

// ===== src/lbp_checker.sv =====
// Port-level checker for lbp_3x3_with_histogram, bound to the top level.
// Uses lbp_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lbp_port_checker
  import lbp_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [PIX_W-1:0] lbp_code,
  input wire logic             code_valid,
  input wire logic             frame_done,
  input wire logic [CNT_W-1:0] bin_count
);

  // a stalled item holds its payload
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(lbp_code) && $stable(code_valid) && $stable(frame_done) && $stable(bin_count), "stalled output item changed")

  // a stalled output freezes the pipeline
  `ASSERT_IMPLY(a_stall_blocks_in, out_valid && !out_ready, !in_ready, "input taken while output stalled")

  // a read item carries nothing but a count
  `ASSERT_IMPLY(a_read_clean, out_valid && bin_count != '0, !code_valid && !frame_done && lbp_code == '0, "read item with pixel fields set")

  // border positions give a zero code
  `ASSERT_IMPLY(a_border_zero, out_valid && !code_valid, lbp_code == '0, "border item with nonzero code")

  // the last pixel of a frame is always an interior centre
  `ASSERT_IMPLY(a_done_interior, out_valid && frame_done, code_valid, "frame end on border item")

endmodule

bind lbp_3x3_with_histogram lbp_port_checker u_lbp_checker (.*);

`default_nettype wire
